>>> design/hsvrgb_pkg.sv
package hsvrgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HUE_W     = 16;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int LVL_W     = 16;
  localparam int H6_W      = HUE_W + 3;
  localparam int SEC_W     = 3;

  localparam logic [Q_W-1:0]  ONE_Q    = Q_W'(1) << FRAC_BITS;
  localparam logic [H6_W-1:0] FULL_H6  = H6_W'(6) << FRAC_BITS;
  localparam logic [LVL_W-1:0] FULL_SCALE_RST = LVL_W'(4095);

  typedef logic [Q_W-1:0]   comp_t;
  typedef logic [LVL_W-1:0] level_t;

  typedef enum logic [SEC_W-1:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    comp_t r;
    comp_t g;
    comp_t b;
  } rgb_comp_t;

  typedef struct packed {
    level_t r;
    level_t g;
    level_t b;
  } rgb_level_t;

endpackage

>>> design/hsv_to_rgb_converter.sv
// HSV to RGB converter. Takes hue (Q0.16 turn), saturation and value
// (17 bits, 65536 = 1.0, larger values clamp to 1.0) and returns red,
// green and blue as truncated component * full_scale >> 16. One color is
// accepted every cycle unless stalled, through a five-register
// pipeline: hue*6 and clamping, the s*f and s*(1-f) products, the three
// v-products for p, q and t, the sector select, and the full-scale
// multiply. Every stage holds under backpressure and bubbles collapse.
// full_scale is sampled at the last stage, so write it only while idle.
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // hue[15:0], saturation[32:16], value[49:33], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // red[15:0], green[31:16], blue[47:32]
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [HUE_W-1:0] in_hue;
  logic [Q_W-1:0]   in_sat;
  logic [Q_W-1:0]   in_val;

  assign in_hue = in_tdata[HUE_W-1:0];
  assign in_sat = in_tdata[HUE_W +: Q_W];
  assign in_val = in_tdata[HUE_W+Q_W +: Q_W];

  level_t full_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= FULL_SCALE_RST;
    end else if (cfg_wr_en) begin
      full_scale_r <= cfg_wr_data;
    end
  end

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage 1: clamp, hue * 6
  logic [H6_W-1:0] h6;
  logic [H6_W-1:0] h6_wrap;
  comp_t           sat_nxt;
  comp_t           val_nxt;
  sector_t         sec1_r;
  logic [FRAC_BITS-1:0] f1_r;
  comp_t           sat1_r;
  comp_t           val1_r;
  logic            zero1_r;

  assign h6      = H6_W'(in_hue) * H6_W'(6);
  assign h6_wrap = (h6 >= FULL_H6) ? '0 : h6;
  assign sat_nxt = (in_sat > ONE_Q) ? ONE_Q : in_sat;
  assign val_nxt = (in_val > ONE_Q) ? ONE_Q : in_val;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sec1_r  <= sector_t'(h6_wrap[FRAC_BITS +: SEC_W]);
      f1_r    <= h6_wrap[FRAC_BITS-1:0];
      sat1_r  <= sat_nxt;
      val1_r  <= val_nxt;
      zero1_r <= (in_sat == '0);
    end
  end

  // stage 2: s*f and s*(1-f)
  comp_t             omf;
  logic [2*Q_W-1:0]  sf_nxt;
  logic [2*Q_W-1:0]  sif_nxt;
  sector_t           sec2_r;
  comp_t             sf2_r;
  comp_t             sif2_r;
  comp_t             oms2_r;
  comp_t             val2_r;
  logic              zero2_r;

  assign omf     = ONE_Q - Q_W'(f1_r);
  assign sf_nxt  = sat1_r * Q_W'(f1_r);
  assign sif_nxt = sat1_r * omf;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sec2_r  <= sec1_r;
      sf2_r   <= sf_nxt[FRAC_BITS +: Q_W];
      sif2_r  <= sif_nxt[FRAC_BITS +: Q_W];
      oms2_r  <= ONE_Q - sat1_r;
      val2_r  <= val1_r;
      zero2_r <= zero1_r;
    end
  end

  // stage 3: p, q, t
  logic [2*Q_W-1:0] p_nxt;
  logic [2*Q_W-1:0] q_nxt;
  logic [2*Q_W-1:0] t_nxt;
  sector_t          sec3_r;
  comp_t            p3_r;
  comp_t            q3_r;
  comp_t            t3_r;
  comp_t            val3_r;
  logic             zero3_r;

  assign p_nxt = val2_r * oms2_r;
  assign q_nxt = val2_r * (ONE_Q - sf2_r);
  assign t_nxt = val2_r * (ONE_Q - sif2_r);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      sec3_r  <= sec2_r;
      p3_r    <= p_nxt[FRAC_BITS +: Q_W];
      q3_r    <= q_nxt[FRAC_BITS +: Q_W];
      t3_r    <= t_nxt[FRAC_BITS +: Q_W];
      val3_r  <= val2_r;
      zero3_r <= zero2_r;
    end
  end

  // stage 4: sector select
  rgb_comp_t comp_nxt;
  rgb_comp_t comp4_r;
  logic      zero4_r;

  always_comb begin
    if (zero3_r) begin
      comp_nxt = '{r: val3_r, g: val3_r, b: val3_r};
    end else begin
      unique case (sec3_r)
        SEC_RED_YEL: comp_nxt = '{r: val3_r, g: t3_r,   b: p3_r};
        SEC_YEL_GRN: comp_nxt = '{r: q3_r,   g: val3_r, b: p3_r};
        SEC_GRN_CYN: comp_nxt = '{r: p3_r,   g: val3_r, b: t3_r};
        SEC_CYN_BLU: comp_nxt = '{r: p3_r,   g: q3_r,   b: val3_r};
        SEC_BLU_MAG: comp_nxt = '{r: t3_r,   g: p3_r,   b: val3_r};
        default:     comp_nxt = '{r: val3_r, g: p3_r,   b: q3_r};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      comp4_r <= comp_nxt;
      zero4_r <= zero3_r;
    end
  end

  // stage 5: full-scale multiply
  rgb_level_t level;

  hsvrgb_scale u_scale (
    .clk        (clk),
    .load       (rdy5),
    .comp       (comp4_r),
    .full_scale (full_scale_r),
    .level      (level)
  );

  assign out_tvalid = v5_r;
  assign out_tdata  = {level.b, level.g, level.r};

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && v5_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline full and stalled");

  a_valid_from_prev: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v4_r))
    else $error("output valid without item in select stage");

  a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && zero4_r) |-> (comp4_r.r == comp4_r.g && comp4_r.g == comp4_r.b))
    else $error("zero saturation did not give grey");

  a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("output data changed during stall");

endmodule

>>> design/hsvrgb_scale.sv
module hsvrgb_scale
  import hsvrgb_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  rgb_comp_t  comp,
  input  level_t     full_scale,
  output rgb_level_t level
);

  logic [Q_W+LVL_W-1:0] prod_r_nxt;
  logic [Q_W+LVL_W-1:0] prod_g_nxt;
  logic [Q_W+LVL_W-1:0] prod_b_nxt;
  rgb_level_t           level_r;

  assign prod_r_nxt = comp.r * full_scale;
  assign prod_g_nxt = comp.g * full_scale;
  assign prod_b_nxt = comp.b * full_scale;

  always_ff @(posedge clk) begin
    if (load) begin
      level_r.r <= prod_r_nxt[FRAC_BITS +: LVL_W];
      level_r.g <= prod_g_nxt[FRAC_BITS +: LVL_W];
      level_r.b <= prod_b_nxt[FRAC_BITS +: LVL_W];
    end
  end

  assign level = level_r;

endmodule

>>> test/hsv_rgb_checker.sv
`timescale 1ns / 1ps

module hsv_rgb_checker
  import hsvrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,   // hue[15:0], saturation[32:16], value[49:33], zero pad
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // red[15:0], green[31:16], blue[47:32]
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          err_cnt,
  output int          pending_cnt,
  output int          checked_cnt
);

  level_t     full_scale_q;
  rgb_level_t expected_rgb[$];

  function automatic rgb_level_t predict_rgb(logic [15:0] hue, logic [16:0] sat,
                                             logic [16:0] val, level_t fs);
    logic [63:0] one, s, v, h6, f, p, q, t, r, g, b;
    sector_t     sec;
    rgb_level_t  res;
    one = 64'(ONE_Q);
    s   = (64'(sat) > one) ? one : 64'(sat);
    v   = (64'(val) > one) ? one : 64'(val);
    if (s == 0) begin
      r = v;
      g = v;
      b = v;
    end else begin
      h6 = 64'(hue) * 64'd6;
      if (h6 >= 64'(FULL_H6)) h6 = 0;
      sec = sector_t'(h6 >> FRAC_BITS);
      f   = h6 & (one - 1);
      p   = (v * (one - s)) >> FRAC_BITS;
      q   = (v * (one - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
      t   = (v * (one - ((s * (one - f)) >> FRAC_BITS))) >> FRAC_BITS;
      case (sec)
        SEC_RED_YEL: begin r = v; g = t; b = p; end
        SEC_YEL_GRN: begin r = q; g = v; b = p; end
        SEC_GRN_CYN: begin r = p; g = v; b = t; end
        SEC_CYN_BLU: begin r = p; g = q; b = v; end
        SEC_BLU_MAG: begin r = t; g = p; b = v; end
        default:     begin r = v; g = p; b = q; end
      endcase
    end
    res.r = level_t'((r * 64'(fs)) >> FRAC_BITS);
    res.g = level_t'((g * 64'(fs)) >> FRAC_BITS);
    res.b = level_t'((b * 64'(fs)) >> FRAC_BITS);
    return res;
  endfunction

  initial begin
    err_cnt      = 0;
    pending_cnt  = 0;
    checked_cnt  = 0;
    full_scale_q = FULL_SCALE_RST;
  end

  always @(posedge clk) begin
    rgb_level_t got, exp_rgb;
    if (!rst_n) begin
      full_scale_q = FULL_SCALE_RST;
      expected_rgb.delete();
    end else begin
      if (cfg_wr_en) full_scale_q = cfg_wr_data;
      if (in_tvalid && in_tready)
        expected_rgb.push_back(predict_rgb(in_tdata[15:0], in_tdata[32:16],
                                           in_tdata[49:33], full_scale_q));
      if (out_tvalid && out_tready) begin
        got.r = out_tdata[15:0];
        got.g = out_tdata[31:16];
        got.b = out_tdata[47:32];
        if (expected_rgb.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transfer, expected none, got r=%0d g=%0d b=%0d",
                   $time, got.r, got.g, got.b);
        end else begin
          exp_rgb = expected_rgb.pop_front();
          checked_cnt++;
          if (got !== exp_rgb) begin
            err_cnt++;
            $display("%0t: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d", $time,
                     exp_rgb.r, exp_rgb.g, exp_rgb.b, got.r, got.g, got.b);
          end
        end
      end
    end
    pending_cnt = expected_rgb.size();
  end

endmodule

>>> test/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;
  import hsvrgb_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_LEN   = 160;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int          err_cnt, pending_cnt, checked_cnt;
  int          cycle_cnt   = 0;
  int          sent_cnt    = 0;
  int          setting_cnt = 1;
  bit          idle_on     = 1'b1;

  hsv_to_rgb_converter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  hsv_rgb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .err_cnt    (err_cnt),
    .pending_cnt(pending_cnt),
    .checked_cnt(checked_cnt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= !idle_on || ($urandom_range(0, 99) >= 14);
  end

  task automatic send_color(input logic [15:0] hue, input logic [16:0] sat,
                            input logic [16:0] val);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, val, sat, hue};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_random_color();
    logic [16:0] sat, val;
    case ($urandom_range(0, 9))
      0:       sat = '0;
      1:       sat = ONE_Q;
      2:       sat = 17'($urandom);
      default: sat = 17'($urandom_range(0, 65536));
    endcase
    case ($urandom_range(0, 9))
      0:       val = '0;
      1:       val = ONE_Q;
      2:       val = 17'($urandom);
      default: val = 17'($urandom_range(0, 65536));
    endcase
    send_color(16'($urandom), sat, val);
  endtask

  // stop sending and wait until every expected transfer is back
  task automatic drain_pipe();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_full_scale(input logic [15:0] fs);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fs;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    setting_cnt++;
  endtask

  initial begin
    logic [15:0] fs_plan[6];
    fs_plan = '{16'd65535, 16'd1, 16'd0, 16'($urandom), FULL_SCALE_RST, 16'($urandom)};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corners under the reset full scale
    send_color(16'd0,     17'd0,      17'd0);
    send_color(16'd0,     17'd0,      17'd65536);
    send_color(16'd12345, 17'd0,      17'd40000);
    send_color(16'd0,     17'd65536,  17'd65536);
    send_color(16'd1,     17'd65536,  17'd65536);
    send_color(16'd10922, 17'd65536,  17'd65536);
    send_color(16'd10923, 17'd65536,  17'd65536);
    send_color(16'd21846, 17'd65536,  17'd65536);
    send_color(16'd32768, 17'd65536,  17'd65536);
    send_color(16'd43691, 17'd65536,  17'd65536);
    send_color(16'd54614, 17'd65536,  17'd65536);
    send_color(16'd65535, 17'd65536,  17'd65536);
    send_color(16'd20000, 17'd131071, 17'd131071);
    send_color(16'd30000, 17'd65537,  17'd65537);
    send_color(16'd40000, 17'd65536,  17'd0);
    send_color(16'd50000, 17'd1,      17'd65536);
    send_color(16'd5000,  17'd32768,  17'd49152);
    send_color(16'd60000, 17'd65535,  17'd65535);
    send_color(16'd25000, 17'd100000, 17'd30000);
    drain_pipe();

    for (int ph = 0; ph < 6; ph++) begin
      write_full_scale(fs_plan[ph]);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (ph == 3) idle_on = (i < 20) || (i >= 140);
        if (ph == 1 && i == 80) drain_pipe();
        send_random_color();
      end
      idle_on = 1'b1;
      drain_pipe();
    end

    repeat (20) @(negedge clk);
    $display("Covered %0d colors (%0d compared) over %0d full_scale settings,",
             sent_cnt, checked_cnt, setting_cnt);
    $display("incl. full_scale 0, 1, 65535, grey, clamped inputs and sector edges.");
    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> hsv_to_rgb_converter.f
design/hsvrgb_pkg.sv
design/hsvrgb_scale.sv
design/hsv_to_rgb_converter.sv
test/hsv_rgb_checker.sv
test/tb_hsv_to_rgb_converter.sv
